// ----- design/rcpva_pkg.sv -----
// rcpva_pkg: shared constants, types and register codes for the rc pulse
// validate and average block. No dependencies; imported by every design file.
package rcpva_pkg;

  // sizing
  localparam int CHANNELS   = 8;
  localparam int WINDOW     = 4;
  localparam int CH_W       = 3;
  localparam int PULSE_W    = 16;
  localparam int SAMPLE_W   = 12;
  localparam int FRAME_W    = 8;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W      = SAMPLE_W + SLOT_W;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // register reset values
  localparam logic [SAMPLE_W-1:0] MID_RESET = SAMPLE_W'(1500);
  localparam logic [SAMPLE_W-1:0] MIN_RESET = SAMPLE_W'(750);
  localparam logic [SAMPLE_W-1:0] MAX_RESET = SAMPLE_W'(2250);

  // register index within the map (word address)
  typedef enum logic [1:0] {
    REG_MID_VALUE   = 2'd0,
    REG_WIDTH_LO    = 2'd1,
    REG_WIDTH_HI    = 2'd2,
    REG_DATA_DRIVEN = 2'd3
  } reg_idx_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [SAMPLE_W-1:0] mid_value;
    logic [SAMPLE_W-1:0] width_lo;
    logic [SAMPLE_W-1:0] width_hi;
    logic                data_driven;
  } cfg_t;

endpackage

// ----- design/rcpva_regs.sv -----
// rcpva_regs: APB-style configuration registers for the rc pulse block.
// Depends on rcpva_pkg for widths, reset values and register codes.
module rcpva_regs
  import rcpva_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mid_value   <= MID_RESET;
      cfg_r.width_lo    <= MIN_RESET;
      cfg_r.width_hi    <= MAX_RESET;
      cfg_r.data_driven <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MID_VALUE:   cfg_r.mid_value   <= pwdata[SAMPLE_W-1:0];
        REG_WIDTH_LO:    cfg_r.width_lo    <= pwdata[SAMPLE_W-1:0];
        REG_WIDTH_HI:    cfg_r.width_hi    <= pwdata[SAMPLE_W-1:0];
        REG_DATA_DRIVEN: cfg_r.data_driven <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_MID_VALUE:   prdata = APB_DATA_W'(cfg_r.mid_value);
      REG_WIDTH_LO:    prdata = APB_DATA_W'(cfg_r.width_lo);
      REG_WIDTH_HI:    prdata = APB_DATA_W'(cfg_r.width_hi);
      REG_DATA_DRIVEN: prdata = APB_DATA_W'(cfg_r.data_driven);
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- design/rc_pulse_validate_average_top.sv -----
// rc_pulse_validate_average_top: input register, window update and average,
// result register. Depends on rcpva_pkg and rcpva_regs.
//
// Conditions one receiver channel pulse width per word. A word is taken into
// an input register, checked against [width_lo, width_hi] (mid_value is
// substituted when out of range or when no source is present), written into
// that channel's four-slot window and, once warmed, averaged, all combinationally
// between the input register and the result register, where the window state is
// also updated. The block takes one word per clock unless the output stalls
// and returns one result per word through the input and result registers;
// its throughput is set only by out_ready, with the result register and
// input register holding one word each while the output stalls. Configuration
// writes must be made while no word is in flight.
module rc_pulse_validate_average_top
  import rcpva_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CH_W-1:0]       in_channel,
  input  logic [PULSE_W-1:0]    in_pulse_width,
  input  logic                  in_new_frame,
  input  logic                  in_source_present,
  // result words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       out_channel,
  output logic [SAMPLE_W-1:0]   out_channel_value,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;

  // input register
  logic                s1_valid_r;
  logic [CH_W-1:0]     s1_channel_r;
  logic [PULSE_W-1:0]  s1_pulse_r;
  logic                s1_new_frame_r;
  logic                s1_present_r;

  // result register
  logic                out_valid_r;
  logic [CH_W-1:0]     out_channel_r;
  logic [SAMPLE_W-1:0] out_value_r;

  // state
  logic [SAMPLE_W-1:0] win_r [CHANNELS][WINDOW];
  logic [FRAME_W-1:0]  frame_count_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                warmed_r;

  // next values and datapath
  logic                s2_ready;
  logic                s1_move;
  logic                frame_adv;
  logic [FRAME_W-1:0]  frame_count_nxt;
  logic [SLOT_W-1:0]   slot_nxt;
  logic                pulse_ok;
  logic [SAMPLE_W-1:0] checked;
  logic                ch_in_range;
  logic                win_wr;
  logic [CH_IDX_W-1:0] ch_idx;
  logic                warmed_nxt;
  logic [SUM_W-1:0]    win_sum;
  logic [SAMPLE_W-1:0] value_nxt;

  rcpva_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // flow control
  assign s2_ready = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && s2_ready;
  assign in_ready = !s1_valid_r || s2_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_channel_r   <= in_channel;
      s1_pulse_r     <= in_pulse_width;
      s1_new_frame_r <= in_new_frame;
      s1_present_r   <= in_source_present;
    end
  end

  // frame counter and window slot, advanced before this word is used
  always_comb begin
    frame_adv       = s1_new_frame_r && !cfg.data_driven;
    frame_count_nxt = frame_count_r;
    slot_nxt        = slot_r;
    if (frame_adv) begin
      frame_count_nxt = frame_count_r + 1'b1;
      if (frame_count_r == {FRAME_W{1'b1}} || slot_r == SLOT_W'(WINDOW - 1)) begin
        slot_nxt = '0;
      end else begin
        slot_nxt = slot_r + 1'b1;
      end
    end
  end

  // range check
  assign pulse_ok = (s1_pulse_r >= PULSE_W'(cfg.width_lo)) &&
                    (s1_pulse_r <= PULSE_W'(cfg.width_hi));
  assign checked  = pulse_ok ? s1_pulse_r[SAMPLE_W-1:0] : cfg.mid_value;

  assign ch_in_range = 32'(s1_channel_r) < CHANNELS;
  assign ch_idx      = s1_channel_r[CH_IDX_W-1:0];
  assign win_wr      = s1_present_r && !cfg.data_driven && ch_in_range;
  assign warmed_nxt  = warmed_r || (win_wr && (32'(frame_count_nxt) >= WINDOW));

  // window sum with the new sample in its slot
  always_comb begin
    win_sum = '0;
    for (int k = 0; k < WINDOW; k++) begin
      if (SLOT_W'(k) == slot_nxt) begin
        win_sum = win_sum + SUM_W'(checked);
      end else begin
        win_sum = win_sum + SUM_W'(win_r[ch_idx][k]);
      end
    end
  end

  // result select
  always_comb begin
    priority if (!s1_present_r) begin
      value_nxt = cfg.mid_value;
    end else if (win_wr && warmed_nxt) begin
      value_nxt = SAMPLE_W'(win_sum / WINDOW);
    end else begin
      value_nxt = checked;
    end
  end

  // state update as the word moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      slot_r        <= '0;
      warmed_r      <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < WINDOW; k++) begin
          win_r[c][k] <= '0;
        end
      end
    end else if (s1_move) begin
      frame_count_r <= frame_count_nxt;
      slot_r        <= slot_nxt;
      warmed_r      <= warmed_nxt;
      if (win_wr) begin
        win_r[ch_idx][slot_nxt] <= checked;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_channel_r <= s1_channel_r;
      out_value_r   <= value_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel       = out_channel_r;
  assign out_channel_value = out_value_r;

  // checks
  a_warmed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    warmed_r |=> warmed_r)
    else $error("warm-up flag cleared");

  a_dd_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.data_driven |=> $stable(frame_count_r))
    else $error("frame counter moved in data-driven mode");

  a_slot_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_count_r == '0) |-> (slot_r == '0))
    else $error("window slot out of step with frame counter");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while both stages are full");

endmodule
